// File: hw/rtl/nec_ir_pkg.sv
// Shared types, constants and the window test for the NEC infrared frame decoder.
// No dependencies; every other file of the block but the checker refers to it by scoped names.
package nec_ir_pkg;

    // Nominal pulse shapes, 100 us units
    localparam logic [7:0] LEAD_W   = 8'd90;
    localparam logic [7:0] START_P  = 8'd135;
    localparam logic [7:0] REPEAT_P = 8'd112;
    localparam logic [7:0] BIT_W    = 8'd6;
    localparam logic [7:0] ZERO_P   = 8'd11;
    localparam logic [7:0] ONE_P    = 8'd22;

    // Frame length and the index of its last bit
    localparam int unsigned FRAME_LEN = 32;
    localparam logic [4:0]  LAST_BIT  = 5'(FRAME_LEN - 1);

    // Register reset values
    localparam logic [15:0] RESET_TIMEOUT = 16'd120;
    localparam logic [3:0]  RESET_TOL     = 4'd2;

    // Register indexes on the configuration port
    localparam logic REG_REPEAT_TIMEOUT = 1'b0;
    localparam logic REG_TOLERANCE      = 1'b1;

    // Request kinds
    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_POLL  = 1'b1;

    typedef enum logic [2:0] {
        SYM_ZERO   = 3'd0,
        SYM_ONE    = 3'd1,
        SYM_START  = 3'd2,
        SYM_REPEAT = 3'd3,
        SYM_BAD    = 3'd4
    } sym_t;

    // Frame assembler to code holder
    typedef struct packed {
        logic       repeat_seen;
        logic       done;
        logic       ok;
        logic [7:0] address;
        logic [7:0] command;
    } frame_evt_t;

    // One result word
    typedef struct packed {
        logic       code_valid;
        logic [7:0] address;
        logic [7:0] command;
        logic       changed;
    } result_t;

    // Wrapping 8-bit window: value within nominal +/- tol
    function automatic logic in_window(input logic [7:0] value, input logic [7:0] nominal,
                                       input logic [3:0] tol);
        logic [7:0] low;
        logic [7:0] diff;
        low  = nominal - {4'd0, tol};
        diff = value - low;
        return diff <= {3'd0, tol, 1'b0};
    endfunction

endpackage

// File: hw/rtl/nec_ir_frame_decoder_core.sv
// NEC infrared frame decoder, top level: input register, classifier, frame
// assembler, code holder and result register. Depends on nec_ir_pkg.
// Path: a word held in the input register moves its result word into the result register on advance.
// Rate: one word per cycle while out_stall does not hold a full result register.
// Reset clears receiver and held code; repeat_timeout resets to 120, tolerance to 2.
module nec_ir_frame_decoder_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  period,
    input  logic [7:0]  width,
    input  logic [31:0] time_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        code_valid,
    output logic [7:0]  address,
    output logic [7:0]  command,
    output logic        changed
);

    logic [15:0]            repeat_timeout_reg;
    logic [3:0]             tolerance_reg;
    logic                   in_valid_reg;
    logic                   req_type_reg;
    logic [7:0]             period_reg;
    logic [7:0]             width_reg;
    logic [TIME_WIDTH-1:0]  time_reg;
    logic                   out_valid_reg;
    nec_ir_pkg::result_t    out_res_reg;
    logic                   advance;
    logic                   pulse;
    nec_ir_pkg::sym_t       sym;
    nec_ir_pkg::frame_evt_t evt;
    nec_ir_pkg::result_t    res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_timeout_reg <= nec_ir_pkg::RESET_TIMEOUT;
            tolerance_reg      <= nec_ir_pkg::RESET_TOL;
        end
        else if (cfg_we)
        begin
            if (cfg_index == nec_ir_pkg::REG_REPEAT_TIMEOUT)
                repeat_timeout_reg <= cfg_data;
            else if (cfg_index == nec_ir_pkg::REG_TOLERANCE)
                tolerance_reg <= cfg_data[3:0];
        end
    end

    // Advance the held word when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign pulse    = in_valid_reg && (req_type_reg == nec_ir_pkg::REQ_PULSE);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_type_reg <= req_type;
            period_reg   <= period;
            width_reg    <= width;
            time_reg     <= time_req[TIME_WIDTH-1:0];
        end
    end

    nec_ir_classify u_classify (
        .period    (period_reg),
        .width     (width_reg),
        .tolerance (tolerance_reg),
        .sym       (sym)
    );

    nec_ir_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .pulse   (pulse),
        .sym     (sym),
        .evt     (evt)
    );

    nec_ir_hold #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_hold (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .evt            (evt),
        .now            (time_reg),
        .repeat_timeout (repeat_timeout_reg),
        .res            (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign code_valid = out_res_reg.code_valid;
    assign address    = out_res_reg.address;
    assign command    = out_res_reg.command;
    assign changed    = out_res_reg.changed;

endmodule

// File: hw/rtl/nec_ir_classify.sv
// Pulse classifier: maps mark width and period to a symbol.
// Depends on nec_ir_pkg.
module nec_ir_classify (
    input  logic [7:0]        period,
    input  logic [7:0]        width,
    input  logic [3:0]        tolerance,
    output nec_ir_pkg::sym_t  sym
);

    logic bit_w;
    logic lead_w;

    assign bit_w  = nec_ir_pkg::in_window(width, nec_ir_pkg::BIT_W, tolerance);
    assign lead_w = nec_ir_pkg::in_window(width, nec_ir_pkg::LEAD_W, tolerance);

    // Bit window first; zero beats one, start beats repeat
    always_comb
    begin
        priority if (bit_w && nec_ir_pkg::in_window(period, nec_ir_pkg::ZERO_P, tolerance))
            sym = nec_ir_pkg::SYM_ZERO;
        else if (bit_w && nec_ir_pkg::in_window(period, nec_ir_pkg::ONE_P, tolerance))
            sym = nec_ir_pkg::SYM_ONE;
        else if (!bit_w && lead_w
                 && nec_ir_pkg::in_window(period, nec_ir_pkg::START_P, tolerance))
            sym = nec_ir_pkg::SYM_START;
        else if (!bit_w && lead_w
                 && nec_ir_pkg::in_window(period, nec_ir_pkg::REPEAT_P, tolerance))
            sym = nec_ir_pkg::SYM_REPEAT;
        else
            sym = nec_ir_pkg::SYM_BAD;
    end

endmodule

// File: hw/rtl/nec_ir_frame.sv
// Frame assembler: collects bits LSB first and flags a completed 32-bit frame.
// Depends on nec_ir_pkg.
module nec_ir_frame (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    pulse,
    input  nec_ir_pkg::sym_t        sym,
    output nec_ir_pkg::frame_evt_t  evt
);

    logic        receiving_reg;
    logic        receiving_next;
    logic [4:0]  bit_count_reg;
    logic [4:0]  bit_count_next;
    logic [31:0] frame_bits_reg;
    logic [31:0] frame_bits_next;
    logic        done;

    // Step the receiver on one symbol
    always_comb
    begin
        receiving_next  = receiving_reg;
        bit_count_next  = bit_count_reg;
        frame_bits_next = frame_bits_reg;
        done            = 1'b0;
        if (pulse && (receiving_reg || sym == nec_ir_pkg::SYM_START))
        begin
            unique case (sym)
                nec_ir_pkg::SYM_ZERO, nec_ir_pkg::SYM_ONE:
                begin
                    if (sym == nec_ir_pkg::SYM_ONE)
                        frame_bits_next = frame_bits_reg | (32'd1 << bit_count_reg);
                    if (bit_count_reg == nec_ir_pkg::LAST_BIT)
                    begin
                        receiving_next = 1'b0;
                        bit_count_next = 5'd0;
                        done           = 1'b1;
                    end
                    else
                        bit_count_next = bit_count_reg + 5'd1;
                end
                nec_ir_pkg::SYM_START:
                begin
                    receiving_next  = 1'b1;
                    bit_count_next  = 5'd0;
                    frame_bits_next = 32'd0;
                end
                nec_ir_pkg::SYM_REPEAT, nec_ir_pkg::SYM_BAD:
                begin
                    receiving_next = 1'b0;
                    bit_count_next = 5'd0;
                end
                default:
                begin
                    receiving_next = 1'b0;
                    bit_count_next = 5'd0;
                end
            endcase
        end
    end

    // Build the frame event; check address and command against their inverted copies
    always_comb
    begin
        evt.repeat_seen = pulse && (sym == nec_ir_pkg::SYM_REPEAT);
        evt.done        = done;
        evt.ok          = (frame_bits_next[7:0] == ~frame_bits_next[15:8])
                       && (frame_bits_next[23:16] == ~frame_bits_next[31:24]);
        evt.address     = frame_bits_next[7:0];
        evt.command     = frame_bits_next[23:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg  <= 1'b0;
            bit_count_reg  <= 5'd0;
            frame_bits_reg <= 32'd0;
        end
        else if (advance)
        begin
            receiving_reg  <= receiving_next;
            bit_count_reg  <= bit_count_next;
            frame_bits_reg <= frame_bits_next;
        end
    end

endmodule

// File: hw/rtl/nec_ir_hold.sv
// Code holder: keeps the last good code and the repeat stamp; a bad frame or the repeat timeout drops it.
// Depends on nec_ir_pkg.
module nec_ir_hold #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  nec_ir_pkg::frame_evt_t  evt,
    input  logic [TIME_WIDTH-1:0]   now,
    input  logic [15:0]             repeat_timeout,
    output nec_ir_pkg::result_t     res
);

    logic                  held_valid_reg;
    logic [7:0]            held_address_reg;
    logic [7:0]            held_command_reg;
    logic [TIME_WIDTH-1:0] repeat_stamp_reg;
    logic [TIME_WIDTH-1:0] repeat_stamp_next;
    logic                  valid_mid;
    logic [7:0]            address_mid;
    logic [7:0]            command_mid;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  expired;

    // Refresh the stamp on a repeat or a completed frame
    assign repeat_stamp_next = (evt.repeat_seen || evt.done) ? now : repeat_stamp_reg;

    // Take a completed frame
    always_comb
    begin
        valid_mid   = held_valid_reg;
        address_mid = held_address_reg;
        command_mid = held_command_reg;
        if (evt.done)
        begin
            valid_mid   = evt.ok;
            address_mid = evt.ok ? evt.address : 8'd0;
            command_mid = evt.ok ? evt.command : 8'd0;
        end
    end

    // Release the code once the timeout has passed
    assign elapsed = now - repeat_stamp_next;
    assign expired = valid_mid && (32'(elapsed) > 32'(repeat_timeout));

    always_comb
    begin
        res.code_valid = valid_mid && !expired;
        res.address    = expired ? 8'd0 : address_mid;
        res.command    = expired ? 8'd0 : command_mid;
        res.changed    = evt.done || expired;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg   <= 1'b0;
            held_address_reg <= 8'd0;
            held_command_reg <= 8'd0;
        end
        else if (advance)
        begin
            held_valid_reg   <= res.code_valid;
            held_address_reg <= res.address;
            held_command_reg <= res.command;
        end
    end

    // Stamp is only read while a code is held
    always_ff @(posedge clk)
    begin
        if (advance)
            repeat_stamp_reg <= repeat_stamp_next;
    end

endmodule

// File: hw/rtl/nec_ir_checker.sv
// Port-level checker for the NEC infrared frame decoder, with its bind statement.
// Depends only on the top level's ports.
module nec_ir_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       code_valid,
    input logic [7:0] address,
    input logic [7:0] command,
    input logic       changed
);

    // Hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_valid) && $stable(address)
            && $stable(command) && $stable(changed))
    else $error("stalled result word changed");

    // Stall input only behind a stalled, full result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

    // No code held means address and command read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !code_valid |-> address == 8'd0 && command == 8'd0)
    else $error("released code shows nonzero bytes");

endmodule

bind nec_ir_frame_decoder_core nec_ir_checker u_nec_ir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_valid (code_valid),
    .address    (address),
    .command    (command),
    .changed    (changed)
);
